// ===== rtl/daa_pkg.sv =====
package daa_pkg;

   localparam int CoefN    = 8;
   localparam int CoefW    = 64;
   localparam int HalfW    = 32;
   localparam int AddrW    = 3;
   localparam int InW      = 16;
   localparam int DW       = 17;   // negated Q1.15 needs one more bit
   localparam int PW       = 49;   // one 17x32 product
   localparam int SW       = 51;   // row sums, trims added
   localparam int AW       = 27;   // magnitude >> 22
   localparam int RW       = 28;   // partial remainder after doubling
   localparam int QW       = 31;   // ratio in units of 2^-30
   localparam int DivSteps = 31;
   localparam int MW       = 40;   // ratio times 400
   localparam int XW       = 26;   // offset value >> 15
   localparam int RecW     = 28;
   localparam int RecK     = 36;
   localparam int OutW     = 16;
   localparam int ReqW     = 72;
   localparam int RspW     = 64;
   localparam int Lanes    = 4;
   localparam int NSt      = DivSteps + 8;

   localparam logic [SW-1:0] SmallRaw   = SW'(64'd2147483);
   localparam logic [SW-1:0] ServoLim   = SW'(64'd200 << 31);
   localparam logic [SW-1:0] MotorOff   = SW'(64'd570 << 31);
   localparam logic [SW-1:0] MotorSpan  = SW'(64'd1000 << 31);
   localparam logic [SW-1:0] ServoOff   = SW'(64'd200 << 31);
   localparam logic [SW-1:0] ServoSpan  = SW'(64'd400 << 31);
   localparam logic [RecW-1:0] RecMotor = RecW'(68719477);  // ceil(2^36 / 1000)
   localparam logic [RecW-1:0] RecServo = RecW'(171798692); // ceil(2^36 / 400)
   localparam logic [8:0] TwiceLim      = 9'd400;

   typedef struct packed {
      logic              en;
      logic              scale;
      logic [1:0]        neg;
      logic [AW-1:0]     mm;
      logic [1:0][RW-1:0] r;
      logic [1:0][QW-1:0] q;
      logic [Lanes-1:0][SW-1:0] dp;
   } div_type;

endpackage

// ===== rtl/duct_actuator_allocation.sv =====
// Actuator allocation for a ducted vehicle: each item (roll, pitch, yaw torque and thrust in
// Q1.15 plus armed and rate-mode flags) is multiplied by a 4x4 Q16.16 matrix from the csr
// registers, the two servo deltas are scaled together to at most 200 us, trims are added and
// every command is normalised and clamped to unsigned Q0.16. With either flag clear all four
// commands are zero. One item is accepted per clock while the output is not stalled; the
// 31-stage bit-per-stage divider that forms the servo ratio makes up most of the pipeline. A
// stalled output holds the whole pipeline, so bubbles do not collapse.
module duct_actuator_allocation (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // torque_roll, torque_pitch, torque_yaw, thrust_down, armed, rates_enabled, zero pad
   input  logic [daa_pkg::ReqW-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // motor_a_cmd, motor_b_cmd, servo_a_cmd, servo_b_cmd
   output logic [daa_pkg::RspW-1:0]   rsp_tdata,
   input  logic                       csr_we,
   input  logic [daa_pkg::AddrW-1:0]  csr_addr,
   input  logic [daa_pkg::CoefW-1:0]  csr_wdata
);
   import daa_pkg::*;

   logic [CoefN-1:0][CoefW-1:0] coef_ff;
   logic [NSt-1:0]              vld_ff, vld_in;
   logic                        adv;

   logic                        en1_ff, en1_in, en2_ff, en3_ff;
   logic [Lanes-1:0][DW-1:0]    d_ff, d_in;
   logic [Lanes-1:0][Lanes-1:0][PW-1:0] p_ff, p_in;
   logic [Lanes-1:0][SW-1:0]    dp_ff, dp_in;
   div_type                     dv_ff [0:DivSteps];
   div_type                     dv_in [0:DivSteps];
   logic                        en4_ff, en5_ff, en6_ff;
   logic [Lanes-1:0][SW-1:0]    sdp_ff, sdp_in;
   logic [Lanes-1:0]            lo_ff, lo_in, hi_ff, hi_in, lo2_ff, hi2_ff;
   logic [Lanes-1:0][XW-1:0]    x_ff, x_in;
   logic [Lanes-1:0][XW+RecW-1:0] m_ff, m_in;
   logic [Lanes-1:0][OutW-1:0]  out_ff, out_in;

   assign adv        = !vld_ff[NSt-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSt-1];
   assign rsp_tdata  = out_ff;
   assign vld_in     = {vld_ff[NSt-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         vld_ff  <= '0;
      end else begin
         if (csr_we)
            coef_ff[csr_addr] <= csr_wdata;
         if (adv)
            vld_ff <= vld_in;
      end
   end

   // stage 1: build D = (-roll, pitch, -yaw, -thrust)
   always_comb begin
      en1_in = req_tdata[4*InW] & req_tdata[4*InW+1];
      d_in[0] = -{req_tdata[InW-1], req_tdata[InW-1:0]};
      d_in[1] = {req_tdata[2*InW-1], req_tdata[2*InW-1:InW]};
      d_in[2] = -{req_tdata[3*InW-1], req_tdata[3*InW-1:2*InW]};
      d_in[3] = -{req_tdata[4*InW-1], req_tdata[4*InW-1:3*InW]};
   end

   // stage 2: sixteen products
   always_comb begin
      for (int r = 0; r < Lanes; r++) begin
         for (int c = 0; c < Lanes; c++) begin
            p_in[r][c] = PW'($signed(d_ff[c]) *
                             $signed(coef_ff[r*2 + c/2][(c%2)*HalfW +: HalfW]));
         end
      end
   end

   // stage 3: row sums
   always_comb begin
      for (int r = 0; r < Lanes; r++) begin
         dp_in[r] = SW'($signed(p_ff[r][0])) + SW'($signed(p_ff[r][1]))
                  + SW'($signed(p_ff[r][2])) + SW'($signed(p_ff[r][3]));
      end
   end

   // stage 4: scale decision, divider set-up; then one quotient bit per stage
   always_comb begin
      logic [SW-1:0] m2, m3, mx;
      logic [RW-1:0] t;
      logic          b;
      m2 = dp_ff[2][SW-1] ? -dp_ff[2] : dp_ff[2];
      m3 = dp_ff[3][SW-1] ? -dp_ff[3] : dp_ff[3];
      mx = (m2 > m3) ? m2 : m3;
      dv_in[0].en    = en3_ff;
      dv_in[0].scale = (m3 > SmallRaw) && (mx > ServoLim);
      dv_in[0].neg   = {dp_ff[3][SW-1], dp_ff[2][SW-1]};
      dv_in[0].mm    = mx[AW+21:22];
      dv_in[0].r[0]  = RW'(m2[AW+21:22]);
      dv_in[0].r[1]  = RW'(m3[AW+21:22]);
      dv_in[0].q     = '0;
      dv_in[0].dp    = dp_ff;
      for (int k = 1; k <= DivSteps; k++) begin
         dv_in[k] = dv_ff[k-1];
         for (int j = 0; j < 2; j++) begin
            // first step compares the plain remainder, later steps double it
            t = (k == 1) ? dv_ff[k-1].r[j] : {dv_ff[k-1].r[j][RW-2:0], 1'b0};
            b = (t >= RW'(dv_ff[k-1].mm));
            dv_in[k].r[j] = b ? t - RW'(dv_ff[k-1].mm) : t;
            dv_in[k].q[j] = {dv_ff[k-1].q[j][QW-2:0], b};
         end
      end
   end

   // servo values become sign * 400 * q when scaled
   always_comb begin
      logic [MW-1:0] mul;
      sdp_in = dv_ff[DivSteps].dp;
      for (int j = 0; j < 2; j++) begin
         mul = MW'(dv_ff[DivSteps].q[j]) * MW'(TwiceLim);
         if (dv_ff[DivSteps].scale)
            sdp_in[j+2] = dv_ff[DivSteps].neg[j] ? -SW'(mul) : SW'(mul);
      end
   end

   // offset, clamp flags, and v >> 15 for the reciprocal divide
   always_comb begin
      logic [SW-1:0] v, span;
      for (int i = 0; i < Lanes; i++) begin
         span     = (i < 2) ? MotorSpan : ServoSpan;
         v        = sdp_ff[i] + ((i < 2) ? MotorOff : ServoOff);
         lo_in[i] = v[SW-1] || (v == '0);
         hi_in[i] = !v[SW-1] && (v >= span);
         x_in[i]  = v[XW+14:15];
      end
   end

   always_comb begin
      for (int i = 0; i < Lanes; i++)
         m_in[i] = (XW+RecW)'(x_ff[i]) * (XW+RecW)'((i < 2) ? RecMotor : RecServo);
   end

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         if (!en6_ff || lo2_ff[i])
            out_in[i] = '0;
         else if (hi2_ff[i])
            out_in[i] = '1;
         else
            out_in[i] = m_ff[i][RecK+OutW-1:RecK];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         en1_ff <= en1_in;
         d_ff   <= d_in;
         en2_ff <= en1_ff;
         p_ff   <= p_in;
         en3_ff <= en2_ff;
         dp_ff  <= dp_in;
         for (int k = 0; k <= DivSteps; k++)
            dv_ff[k] <= dv_in[k];
         en4_ff <= dv_ff[DivSteps].en;
         sdp_ff <= sdp_in;
         en5_ff <= en4_ff;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         x_ff   <= x_in;
         en6_ff <= en5_ff;
         lo2_ff <= lo_ff;
         hi2_ff <= hi_ff;
         m_ff   <= m_in;
         out_ff <= out_in;
      end
   end

endmodule
